[rtl/rbu_pkg.sv]
`timescale 1ns / 1ps

package rbu_pkg;

	localparam int PIX_W      = 16;
	localparam int CHAN_W     = 8;
	localparam int MODE_W     = 3;
	localparam int AMOUNT_W   = 10;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// blend modes; code 7 falls back to copy
	localparam logic [MODE_W-1:0] MODE_COPY        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INTENSITY   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TRANSLUCENT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TINT        = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LUMA        = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DESAT       = 3'd5;
	localparam logic [MODE_W-1:0] MODE_MAX         = 3'd6;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AMOUNT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TINT_R = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TINT_G = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TINT_B = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SWAP   = 3'd5;

	localparam logic [AMOUNT_W-1:0] AMOUNT_RESET = 10'd256;

	// luminance weights, Q8
	localparam logic [CHAN_W-1:0] LUMA_R = 8'd77;
	localparam logic [CHAN_W-1:0] LUMA_G = 8'd151;
	localparam logic [CHAN_W-1:0] LUMA_B = 8'd28;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [AMOUNT_W-1:0] amount;
		logic [CHAN_W-1:0]   tint_r;
		logic [CHAN_W-1:0]   tint_g;
		logic [CHAN_W-1:0]   tint_b;
		logic                swap;
	} cfg_t;

	function automatic logic [CHAN_W-1:0] chan_r(input logic [PIX_W-1:0] p);
		return {p[15:11], 3'b000};
	endfunction

	function automatic logic [CHAN_W-1:0] chan_g(input logic [PIX_W-1:0] p);
		return {p[10:5], 2'b00};
	endfunction

	function automatic logic [CHAN_W-1:0] chan_b(input logic [PIX_W-1:0] p);
		return {p[4:0], 3'b000};
	endfunction

	function automatic logic [PIX_W-1:0] pack565(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

[rtl/rbu_in_if.sv]
`timescale 1ns / 1ps

interface rbu_in_if;
	logic                       valid;
	logic                       ready;
	logic [rbu_pkg::PIX_W-1:0]  src_pixel;
	logic [rbu_pkg::PIX_W-1:0]  dst_pixel;

	modport source(output valid, output src_pixel, output dst_pixel, input ready);
	modport sink(input valid, input src_pixel, input dst_pixel, output ready);
endinterface

[rtl/rbu_out_if.sv]
`timescale 1ns / 1ps

interface rbu_out_if;
	logic                       valid;
	logic                       ready;
	logic [rbu_pkg::PIX_W-1:0]  out_pixel;

	modport source(output valid, output out_pixel, input ready);
	modport sink(input valid, input out_pixel, output ready);
endinterface

[rtl/rgb565_blend_unit_core.sv]
`timescale 1ns / 1ps

// RGB565 blend unit. Each beat on pix_in carries a source and a destination
// pixel; pix_out returns one blended pixel per beat, in order. The unit takes
// one pixel per clock and carries it through an input register, a product
// register and an output register. The whole pipeline advances together:
// it stalls only while a finished pixel waits at pix_out, so throughput is
// one pixel per cycle whenever the sink keeps ready high. The mode register
// picks copy, intensity, translucency, tint, or one of three grayscale forms;
// swap exchanges the roles of the two pixels, and a source of zero passes the
// destination through untouched. Amount is fixed point with AMOUNT_FRAC_BITS
// fraction bits. Write the config registers only while the pipeline is empty.
module rgb565_blend_unit_core #(
	parameter int AMOUNT_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbu_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [rbu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	rbu_in_if.sink                            pix_in,
	rbu_out_if.source                         pix_out
);

	localparam int AW = (AMOUNT_FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(AMOUNT_FRAC_BITS + 1) : rbu_pkg::AMOUNT_W;
	localparam int PW = rbu_pkg::CHAN_W + AW;

	// ---------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------
	rbu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= rbu_pkg::MODE_COPY;
			cfg_q.amount <= rbu_pkg::AMOUNT_RESET;
			cfg_q.tint_r <= '0;
			cfg_q.tint_g <= '0;
			cfg_q.tint_b <= '0;
			cfg_q.swap   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbu_pkg::REG_MODE:   cfg_q.mode   <= cfg_wdata[rbu_pkg::MODE_W-1:0];
				rbu_pkg::REG_AMOUNT: cfg_q.amount <= cfg_wdata[rbu_pkg::AMOUNT_W-1:0];
				rbu_pkg::REG_TINT_R: cfg_q.tint_r <= cfg_wdata[rbu_pkg::CHAN_W-1:0];
				rbu_pkg::REG_TINT_G: cfg_q.tint_g <= cfg_wdata[rbu_pkg::CHAN_W-1:0];
				rbu_pkg::REG_TINT_B: cfg_q.tint_b <= cfg_wdata[rbu_pkg::CHAN_W-1:0];
				rbu_pkg::REG_SWAP:   cfg_q.swap   <= cfg_wdata[0];
				default: ; // unknown index: ignored
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline advance: move everything unless the output beat is stuck
	// ---------------------------------------------------------------
	logic adv;
	logic valid_s1, valid_s2, valid_s3;

	assign adv          = !valid_s3 || pix_out.ready;
	assign pix_in.ready = adv;

	// ---------------------------------------------------------------
	// Stage 1: role swap, transparency detect
	// ---------------------------------------------------------------
	logic [rbu_pkg::PIX_W-1:0] spix_s1, dpix_s1, pass_s1;
	logic                      transp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// source term always comes from spix, destination term from dpix
			spix_s1   <= cfg_q.swap ? pix_in.dst_pixel : pix_in.src_pixel;
			dpix_s1   <= cfg_q.swap ? pix_in.src_pixel : pix_in.dst_pixel;
			pass_s1   <= pix_in.dst_pixel;
			transp_s1 <= (pix_in.src_pixel == '0);
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: per-channel products and gray value
	// ---------------------------------------------------------------
	logic [2:0][rbu_pkg::CHAN_W-1:0] cs_ch, cd_ch, tint_ch;
	logic [2:0][PW-1:0]              p1_c, p2_c;

	assign cs_ch[0]   = rbu_pkg::chan_r(spix_s1);
	assign cs_ch[1]   = rbu_pkg::chan_g(spix_s1);
	assign cs_ch[2]   = rbu_pkg::chan_b(spix_s1);
	assign cd_ch[0]   = rbu_pkg::chan_r(dpix_s1);
	assign cd_ch[1]   = rbu_pkg::chan_g(dpix_s1);
	assign cd_ch[2]   = rbu_pkg::chan_b(dpix_s1);
	assign tint_ch[0] = cfg_q.tint_r;
	assign tint_ch[1] = cfg_q.tint_g;
	assign tint_ch[2] = cfg_q.tint_b;

	for (genvar k = 0; k < 3; k++) begin : g_chan
		rbu_chan_mul #(
			.FRAC_BITS (AMOUNT_FRAC_BITS)
		) u_mul (
			.mode   (cfg_q.mode),
			.amount (cfg_q.amount),
			.tint   (tint_ch[k]),
			.cs     (cs_ch[k]),
			.cd     (cd_ch[k]),
			.p1     (p1_c[k]),
			.p2     (p2_c[k])
		);
	end

	// grayscale: luminance, (max+min)/2, or max
	logic [15:0]               luma_r, luma_g, luma_b;
	logic [8:0]                luma_sum;
	logic [rbu_pkg::CHAN_W-1:0] mx, mn, gray_c;
	logic [8:0]                mxmn;

	always_comb begin
		luma_r   = 16'(cs_ch[0]) * 16'(rbu_pkg::LUMA_R);
		luma_g   = 16'(cs_ch[1]) * 16'(rbu_pkg::LUMA_G);
		luma_b   = 16'(cs_ch[2]) * 16'(rbu_pkg::LUMA_B);
		luma_sum = 9'(luma_r[15:8]) + 9'(luma_g[15:8]) + 9'(luma_b[15:8]);

		mx = (cs_ch[0] > cs_ch[1]) ? cs_ch[0] : cs_ch[1];
		mx = (mx > cs_ch[2]) ? mx : cs_ch[2];
		mn = (cs_ch[0] < cs_ch[1]) ? cs_ch[0] : cs_ch[1];
		mn = (mn < cs_ch[2]) ? mn : cs_ch[2];
		mxmn = 9'(mx) + 9'(mn);

		case (cfg_q.mode)
			rbu_pkg::MODE_LUMA:  gray_c = luma_sum[7:0]; // peaks at 249
			rbu_pkg::MODE_DESAT: gray_c = mxmn[8:1];
			default:             gray_c = mx;
		endcase
	end

	logic [2:0][PW-1:0]         p1_s2, p2_s2;
	logic [rbu_pkg::CHAN_W-1:0] gray_s2;
	logic [rbu_pkg::PIX_W-1:0]  spix_s2, pass_s2;
	logic                       transp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2     <= p1_c;
			p2_s2     <= p2_c;
			gray_s2   <= gray_c;
			spix_s2   <= spix_s1;
			pass_s2   <= pass_s1;
			transp_s2 <= transp_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: saturate, pack, sum; this is the output register
	// ---------------------------------------------------------------
	logic [rbu_pkg::PIX_W-1:0] res_c;
	logic [rbu_pkg::PIX_W-1:0] out_s3;

	rbu_term_pack #(
		.FRAC_BITS (AMOUNT_FRAC_BITS)
	) u_pack (
		.mode   (cfg_q.mode),
		.transp (transp_s2),
		.pass   (pass_s2),
		.spix   (spix_s2),
		.gray   (gray_s2),
		.p1     (p1_s2),
		.p2     (p2_s2),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s3 <= res_c;
		end
	end

	assign pix_out.valid     = valid_s3;
	assign pix_out.out_pixel = out_s3;

endmodule

[rtl/rbu_chan_mul.sv]
`timescale 1ns / 1ps

// Two factor products for one color channel; operands chosen by mode.
module rbu_chan_mul #(
	parameter int FRAC_BITS = 8
) (
	input  logic [rbu_pkg::MODE_W-1:0]   mode,
	input  logic [rbu_pkg::AMOUNT_W-1:0] amount,
	input  logic [rbu_pkg::CHAN_W-1:0]   tint,
	input  logic [rbu_pkg::CHAN_W-1:0]   cs,
	input  logic [rbu_pkg::CHAN_W-1:0]   cd,
	output logic [rbu_pkg::CHAN_W + ((FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W) - 1:0] p1,
	output logic [rbu_pkg::CHAN_W + ((FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W) - 1:0] p2
);

	localparam int AW = (FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W;
	localparam int PW = rbu_pkg::CHAN_W + AW;
	localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

	logic [AW-1:0]               amt_x;
	logic [AW-1:0]               ca;
	logic [AW-1:0]               inv_ca;
	logic [AW-1:0]               m1;
	logic [AW-1:0]               m2;
	logic [rbu_pkg::CHAN_W-1:0]  x2;

	always_comb begin
		amt_x  = AW'(amount);
		ca     = (amt_x > ONE) ? ONE : amt_x;
		inv_ca = ONE - ca;
		m1     = '0;
		m2     = '0;
		x2     = cd;
		case (mode)
			rbu_pkg::MODE_INTENSITY: begin
				m1 = amt_x;
			end
			rbu_pkg::MODE_TRANSLUCENT: begin
				m1 = ca;
				m2 = inv_ca;
				x2 = cd;
			end
			rbu_pkg::MODE_TINT: begin
				// (1-a)*c + a*T
				m1 = inv_ca;
				m2 = ca;
				x2 = tint;
			end
			default: begin
				m1 = '0;
			end
		endcase
	end

	assign p1 = PW'(cs) * PW'(m1);
	assign p2 = PW'(x2) * PW'(m2);

endmodule

[rtl/rbu_term_pack.sv]
`timescale 1ns / 1ps

// Final stage: shift, saturate, pack both terms and add them mod 2^16; a transparent source passes the destination.
module rbu_term_pack #(
	parameter int FRAC_BITS = 8
) (
	input  logic [rbu_pkg::MODE_W-1:0] mode,
	input  logic                       transp,
	input  logic [rbu_pkg::PIX_W-1:0]  pass,
	input  logic [rbu_pkg::PIX_W-1:0]  spix,
	input  logic [rbu_pkg::CHAN_W-1:0] gray,
	input  logic [2:0][rbu_pkg::CHAN_W + ((FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W) - 1:0] p1,
	input  logic [2:0][rbu_pkg::CHAN_W + ((FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W) - 1:0] p2,
	output logic [rbu_pkg::PIX_W-1:0]  res
);

	localparam int AW = (FRAC_BITS + 1 > rbu_pkg::AMOUNT_W) ?
		(FRAC_BITS + 1) : rbu_pkg::AMOUNT_W;
	localparam int PW = rbu_pkg::CHAN_W + AW;

	function automatic logic [rbu_pkg::CHAN_W-1:0] sat_shift(input logic [PW:0] v);
		logic [PW:0] sh;
		sh = v >> FRAC_BITS;
		return (sh > (PW + 1)'(255)) ? 8'hFF : sh[7:0];
	endfunction

	logic [2:0][rbu_pkg::CHAN_W-1:0] s_ch;
	logic [2:0][rbu_pkg::CHAN_W-1:0] d_ch;
	logic [2:0][rbu_pkg::CHAN_W-1:0] t_ch;
	logic [rbu_pkg::PIX_W-1:0]       s_term;
	logic [rbu_pkg::PIX_W-1:0]       d_term;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_ch[k] = sat_shift({1'b0, p1[k]});
			d_ch[k] = sat_shift({1'b0, p2[k]});
			t_ch[k] = sat_shift({1'b0, p1[k]} + {1'b0, p2[k]});
		end

		case (mode) inside
			rbu_pkg::MODE_INTENSITY, rbu_pkg::MODE_TRANSLUCENT:
				s_term = rbu_pkg::pack565(s_ch[0], s_ch[1], s_ch[2]);
			rbu_pkg::MODE_TINT:
				s_term = rbu_pkg::pack565(t_ch[0], t_ch[1], t_ch[2]);
			rbu_pkg::MODE_LUMA, rbu_pkg::MODE_DESAT, rbu_pkg::MODE_MAX:
				s_term = rbu_pkg::pack565(gray, gray, gray);
			rbu_pkg::MODE_COPY:
				s_term = spix;
			default:
				s_term = spix;
		endcase

		d_term = (mode == rbu_pkg::MODE_TRANSLUCENT) ?
			rbu_pkg::pack565(d_ch[0], d_ch[1], d_ch[2]) : '0;

		res = transp ? pass : (s_term + d_term);
	end

endmodule

[rtl/rbu_checker.sv]
`timescale 1ns / 1ps

module rbu_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [rbu_pkg::PIX_W-1:0] src_pixel,
	input logic [rbu_pkg::PIX_W-1:0] dst_pixel,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rbu_pkg::PIX_W-1:0] out_pixel
);

	// held output beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel))
		else $error("output beat changed while stalled");

	// an empty output slot never blocks the input
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a waiting output beat holds the input back
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// transparent source comes out as the destination when the pipeline does not stall
	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && src_pixel == '0) ##1 in_ready ##1 in_ready
		|=> out_valid && out_pixel == $past(dst_pixel, 3))
		else $error("transparent pixel not passed through");

endmodule

bind rgb565_blend_unit_core rbu_checker u_rbu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.src_pixel (pix_in.src_pixel),
	.dst_pixel (pix_in.dst_pixel),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.out_pixel)
);

[bench/rbu_blend_check.sv]
`timescale 1ns / 1ps

module rbu_blend_check #(
	parameter int AMOUNT_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbu_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [rbu_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rbu_in_if                              pix_in,
	rbu_out_if                             pix_out,
	output int                             errors,
	output int                             pending
);

	localparam int unsigned ONE        = 1 << AMOUNT_FRAC_BITS;
	localparam int unsigned LUMA_SHIFT = 8;

	rbu_pkg::cfg_t              shadow;
	logic [rbu_pkg::PIX_W-1:0]  blended_q[$];
	logic [rbu_pkg::PIX_W-1:0]  want;

	// 8-bit channels of a 565 pixel
	function automatic void split565(input logic [rbu_pkg::PIX_W-1:0] p,
		output int unsigned r, output int unsigned g, output int unsigned b);
		r = {24'd0, p[15:11], 3'd0};
		g = {24'd0, p[10:5], 2'd0};
		b = {24'd0, p[4:0], 3'd0};
	endfunction

	// any channel over 255 goes to its full mask
	function automatic logic [rbu_pkg::PIX_W-1:0] pack_sat(input int unsigned r,
		input int unsigned g, input int unsigned b);
		logic [rbu_pkg::PIX_W-1:0] p;
		p[15:11] = (r > 255) ? 5'h1f : r[7:3];
		p[10:5]  = (g > 255) ? 6'h3f : g[7:2];
		p[4:0]   = (b > 255) ? 5'h1f : b[7:3];
		return p;
	endfunction

	function automatic int unsigned amount_clamped();
		return (shadow.amount > ONE) ? ONE : 32'(shadow.amount);
	endfunction

	function automatic logic [rbu_pkg::PIX_W-1:0] front_term(
		input logic [rbu_pkg::PIX_W-1:0] p);
		int unsigned r, g, b, a, mx, mn, y;
		split565(p, r, g, b);
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		case (shadow.mode)
			rbu_pkg::MODE_INTENSITY: begin
				a = 32'(shadow.amount);
				return pack_sat((r * a) >> AMOUNT_FRAC_BITS, (g * a) >> AMOUNT_FRAC_BITS,
					(b * a) >> AMOUNT_FRAC_BITS);
			end
			rbu_pkg::MODE_TRANSLUCENT: begin
				a = amount_clamped();
				return pack_sat((r * a) >> AMOUNT_FRAC_BITS, (g * a) >> AMOUNT_FRAC_BITS,
					(b * a) >> AMOUNT_FRAC_BITS);
			end
			rbu_pkg::MODE_TINT: begin
				a = amount_clamped();
				return pack_sat((a * shadow.tint_r + (ONE - a) * r) >> AMOUNT_FRAC_BITS,
					(a * shadow.tint_g + (ONE - a) * g) >> AMOUNT_FRAC_BITS,
					(a * shadow.tint_b + (ONE - a) * b) >> AMOUNT_FRAC_BITS);
			end
			rbu_pkg::MODE_LUMA: begin
				y = ((r * rbu_pkg::LUMA_R) >> LUMA_SHIFT) +
					((g * rbu_pkg::LUMA_G) >> LUMA_SHIFT) +
					((b * rbu_pkg::LUMA_B) >> LUMA_SHIFT);
				return pack_sat(y, y, y);
			end
			rbu_pkg::MODE_DESAT: begin
				y = (mx + mn) >> 1;
				return pack_sat(y, y, y);
			end
			rbu_pkg::MODE_MAX:
				return pack_sat(mx, mx, mx);
			default:
				return p;
		endcase
	endfunction

	function automatic logic [rbu_pkg::PIX_W-1:0] back_term(
		input logic [rbu_pkg::PIX_W-1:0] p);
		int unsigned r, g, b, w;
		if (shadow.mode != rbu_pkg::MODE_TRANSLUCENT)
			return '0;
		split565(p, r, g, b);
		w = ONE - amount_clamped();
		return pack_sat((r * w) >> AMOUNT_FRAC_BITS, (g * w) >> AMOUNT_FRAC_BITS,
			(b * w) >> AMOUNT_FRAC_BITS);
	endfunction

	// sum of both terms, wrapping at 16 bits; a zero source returns the destination
	function automatic logic [rbu_pkg::PIX_W-1:0] blend_pixel(
		input logic [rbu_pkg::PIX_W-1:0] s, input logic [rbu_pkg::PIX_W-1:0] d);
		if (s == '0)
			return d;
		if (shadow.swap)
			return back_term(s) + front_term(d);
		return front_term(s) + back_term(d);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow.mode   = rbu_pkg::MODE_COPY;
			shadow.amount = rbu_pkg::AMOUNT_RESET;
			shadow.tint_r = '0;
			shadow.tint_g = '0;
			shadow.tint_b = '0;
			shadow.swap   = 1'b0;
			blended_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (pix_in.valid && pix_in.ready)
				blended_q.push_back(blend_pixel(pix_in.src_pixel, pix_in.dst_pixel));
			if (pix_out.valid && pix_out.ready) begin
				if (blended_q.size() == 0) begin
					$error("out_pixel: expected none, got %h", pix_out.out_pixel);
					errors++;
				end else begin
					want = blended_q.pop_front();
					if (pix_out.out_pixel !== want) begin
						$error("out_pixel: expected %h, got %h", want, pix_out.out_pixel);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					rbu_pkg::REG_MODE:
						shadow.mode   = cfg_wdata[rbu_pkg::MODE_W-1:0];
					rbu_pkg::REG_AMOUNT:
						shadow.amount = cfg_wdata[rbu_pkg::AMOUNT_W-1:0];
					rbu_pkg::REG_TINT_R:
						shadow.tint_r = cfg_wdata[rbu_pkg::CHAN_W-1:0];
					rbu_pkg::REG_TINT_G:
						shadow.tint_g = cfg_wdata[rbu_pkg::CHAN_W-1:0];
					rbu_pkg::REG_TINT_B:
						shadow.tint_b = cfg_wdata[rbu_pkg::CHAN_W-1:0];
					rbu_pkg::REG_SWAP:
						shadow.swap   = cfg_wdata[0];
					default: ;
				endcase
			end
			pending = blended_q.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int FRAC_BITS   = 8;
	localparam int NUM_ITEMS   = 650;
	localparam int RESET_CYC   = 12;
	// input, product and output register
	localparam int PIPE_DEPTH  = 3;
	localparam int DRAIN_CYC   = PIPE_DEPTH + 2;
	// cycles with no beat on either side before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_GAP     = 8;
	localparam int DW          = rbu_pkg::CFG_DATA_W;
	localparam int PW          = rbu_pkg::PIX_W;

	// indexes the block has no register for; writes there must do nothing
	localparam logic [rbu_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [rbu_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rbu_pkg::REG_IDX_W-1:0]  cfg_index;
	logic [rbu_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int                             errors;
	int                             pending;
	// set per phase: both sides run back to back
	bit                             no_idle;

	rbu_in_if  pix_in();
	rbu_out_if pix_out();

	rgb565_blend_unit_core #(
		.AMOUNT_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	rbu_blend_check #(
		.AMOUNT_FRAC_BITS(FRAC_BITS)
	) i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// mostly random pixels; transparent source and all-ones show up often
	function automatic logic [rbu_pkg::PIX_W-1:0] draw_pixel();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			2:       return 16'hf81f;
			default: return PW'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	// one register write; inputs move on the falling edge only
	task automatic write_reg(input logic [rbu_pkg::REG_IDX_W-1:0] idx,
		input logic [rbu_pkg::CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic apply_cfg(input logic [rbu_pkg::CFG_DATA_W-1:0] mode,
		input logic [rbu_pkg::CFG_DATA_W-1:0] amount,
		input logic [rbu_pkg::CFG_DATA_W-1:0] tr,
		input logic [rbu_pkg::CFG_DATA_W-1:0] tg,
		input logic [rbu_pkg::CFG_DATA_W-1:0] tb,
		input logic [rbu_pkg::CFG_DATA_W-1:0] swap);
		write_reg(rbu_pkg::REG_MODE, mode);
		write_reg(rbu_pkg::REG_AMOUNT, amount);
		write_reg(rbu_pkg::REG_TINT_R, tr);
		write_reg(rbu_pkg::REG_TINT_G, tg);
		write_reg(rbu_pkg::REG_TINT_B, tb);
		write_reg(rbu_pkg::REG_SWAP, swap);
	endtask

	// drop valid, let every outstanding pixel come back, then DRAIN_CYC spare
	// cycles so the pipe is empty before registers change
	task automatic settle();
		pix_in.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// one input beat; entered and left on a falling edge. A zero gap keeps
	// valid high straight into the next beat.
	task automatic send_pixel(input logic [rbu_pkg::PIX_W-1:0] s,
		input logic [rbu_pkg::PIX_W-1:0] d);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid     = 1'b1;
		pix_in.src_pixel = s;
		pix_in.dst_pixel = d;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
	endtask

	// random settings, extremes drawn on purpose; out-of-range data checks
	// that only the low bits of each register are kept
	task automatic random_cfg();
		logic [rbu_pkg::CFG_DATA_W-1:0] mode, amount, swap;
		logic [rbu_pkg::CFG_DATA_W-1:0] tint[3];
		mode = DW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) :
			$urandom_range(0, 7));
		case ($urandom_range(0, 5))
			0:       amount = '0;
			1:       amount = rbu_pkg::AMOUNT_RESET;
			2:       amount = '1;
			3:       amount = DW'(32'(rbu_pkg::AMOUNT_RESET) + $urandom_range(0, 2) - 1);
			default: amount = DW'($urandom_range(0, 1023));
		endcase
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
				0:       tint[k] = '0;
				1:       tint[k] = 10'd255;
				default: tint[k] = DW'($urandom_range(0, 1023));
			endcase
		end
		swap = DW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
			$urandom_range(0, 1));
		apply_cfg(mode, amount, tint[0], tint[1], tint[2], swap);
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
				DW'($urandom_range(0, 1023)));
	endtask

	// sink side: fresh stall before every beat it takes
	initial begin
		int stall;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				pix_out.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_out.ready = 1'b1;
			do @(posedge clk); while (!pix_out.valid);
			@(negedge clk);
		end
	end

	// watchdog: any beat on either channel clears the count
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
				idle = 0;
			else
				idle++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int sent;
		int run_len;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		pix_in.valid     = 1'b0;
		pix_in.src_pixel = '0;
		pix_in.dst_pixel = '0;
		no_idle          = 1'b0;
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// two beats on reset settings before anything is written
		send_pixel(16'h1234, 16'hffff);
		send_pixel('0, 16'habcd);

		// directed: every mode code including the unused one, with swap on odd
		// codes; oversize amount everywhere except translucency, where a
		// partial weight shows both terms. Beats: transparent source,
		// all ones over all ones, magenta over green.
		for (int m = 0; m < 8; m++) begin
			settle();
			apply_cfg(DW'(m), (m == rbu_pkg::MODE_TRANSLUCENT) ? 10'd64 : 10'd1023,
				10'd255, 10'd0, 10'd170, DW'(m % 2));
			send_pixel('0, 16'hffff);
			send_pixel(16'hffff, 16'hffff);
			send_pixel(16'hf81f, 16'h07e0);
		end

		// random phases: new settings, random run length, some phases with no
		// idling on either side
		sent = 0;
		while (sent < NUM_ITEMS) begin
			settle();
			random_cfg();
			no_idle = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(10, 40);
			for (int k = 0; k < run_len; k++) begin
				send_pixel(draw_pixel(), draw_pixel());
				sent++;
			end
		end

		no_idle = 1'b0;
		settle();
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
